// ----- src/rrlcg_pkg.sv -----
package rrlcg_pkg;

   // Number of interleaved generators and the selector width that indexes them.
   localparam int NUM_GENERATORS = 3;
   localparam int SEL_W = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;

   // Generator arithmetic.
   localparam int STATE_W = 32;
   localparam logic [STATE_W-1:0] LCG_MUL = 32'd214013;
   localparam logic [STATE_W-1:0] LCG_ADD = 32'd2531011;
   localparam int SAMPLE_LSB = 16;
   localparam int SAMPLE_W = 15;

   // Request and response field widths.
   localparam int BOUND_W = 16;
   localparam int RSP_DATA_W = 16;

   // Remainder unit step count and counter width.
   localparam int DIV_STEPS = SAMPLE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Command from the sequencer to the remainder unit.
   typedef struct packed {
      logic start;
   } div_cmd_type;

   // Status from the remainder unit back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_STEP = 3'b010,
      ST_DIV  = 3'b100
   } seq_state_type;

endpackage

// ----- src/rrlcg_divider.sv -----
module rrlcg_divider
   import rrlcg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_cmd_type         cmd,
   input  logic [SAMPLE_W-1:0] dividend,
   input  logic [BOUND_W-1:0]  divisor,
   output div_status_type      status,
   output logic [SAMPLE_W-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BOUND_W-1:0]   rem_ff, rem_in;
   logic [SAMPLE_W-1:0]  dvd_ff, dvd_in;
   logic [BOUND_W-1:0]   dsr_ff, dsr_in;
   logic [BOUND_W:0]     trial;
   logic [BOUND_W:0]     diff;

   // One restoring step: shift in the next dividend bit and subtract if it fits.
   always_comb begin
      trial = {rem_ff, dvd_ff[SAMPLE_W-1]};
      diff  = trial - {1'b0, dsr_ff};
   end

   // Sequencing of the shared subtractor over the dividend bits.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[BOUND_W] ? trial[BOUND_W-1:0] : diff[BOUND_W-1:0];
         dvd_in = {dvd_ff[SAMPLE_W-2:0], 1'b0};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   // The remainder never exceeds the dividend, so the low bits hold it all.
   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff[SAMPLE_W-1:0];

endmodule

// ----- src/round_robin_lcg_bounded_random.sv -----
// Channel   Ports                     Content
// request   req_tvalid/tready/tdata   tdata[15:0] = bound
// response  rsp_tvalid/tready/tdata   tdata[14:0] = value, tdata[15] = 0
//           rsp_tuser                 tuser[0] = bad_bound
//
// After acceptance a request steps the selected generator with the multiply-add,
// runs the bit-serial remainder unit over the sample bits and loads the response
// register; the next request is taken only once the sequencer is back in idle.
// Reset is synchronous and clears all generator states and the selector.
// A stalled response holds in its register; the next request is still taken
// and waits at the end of its division until the response slot is free.
module round_robin_lcg_bounded_random
   import rrlcg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BOUND_W-1:0]    req_tdata,   // [15:0] bound
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [14:0] value, [15] zero fill
   output logic                  rsp_tuser    // [0] bad_bound
);

   seq_state_type        state_ff, state_in;
   logic [SEL_W-1:0]     sel_ff, sel_in;
   logic [STATE_W-1:0]   gen_ff [NUM_GENERATORS];
   logic [BOUND_W-1:0]   bound_ff, bound_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                 rsp_bad_ff, rsp_bad_in;
   logic [STATE_W-1:0]   lcg_next;
   logic                 req_take;
   logic                 slot_free;
   logic                 finish;
   div_cmd_type          div_cmd;
   div_status_type       div_status;
   logic [SAMPLE_W-1:0]  div_rem;

   assign req_take  = req_tvalid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign finish    = (state_ff == ST_DIV) && div_status.done && slot_free;

   // Generator update for the selected state, modulo 2^32.
   assign lcg_next = gen_ff[sel_ff] * LCG_MUL + LCG_ADD;

   // Sequencer and selector advance.
   always_comb begin
      state_in    = state_ff;
      sel_in      = sel_ff;
      bound_in    = bound_ff;
      div_cmd     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               bound_in = req_tdata;
               if (sel_ff >= SEL_W'(NUM_GENERATORS - 1)) begin
                  sel_in = '0;
               end else begin
                  sel_in = sel_ff + SEL_W'(1);
               end
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            div_cmd.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register; a zero bound forces the value to zero.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_bad_in   = (bound_ff == '0);
         rsp_value_in = (bound_ff == '0) ? '0 : div_rem;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Generator states: only the selected one advances, in the step cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GENERATORS; i++) begin
            gen_ff[i] <= '0;
         end
      end else if (state_ff == ST_STEP) begin
         gen_ff[sel_ff] <= lcg_next;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bound_ff     <= bound_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // Shared bit-serial remainder unit.
   rrlcg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (lcg_next[SAMPLE_LSB +: SAMPLE_W]),
      .divisor   (bound_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff};
   assign rsp_tuser  = rsp_bad_ff;

   // The selector always indexes an existing generator.
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      sel_ff <= SEL_W'(NUM_GENERATORS - 1))
      else $error("selector out of range");

   // A flagged response carries a zero value.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad bound response with nonzero value");

   // A freshly loaded good response lies below its bound.
   a_below_bound: assert property (@(posedge clock) disable iff (reset)
      finish && (bound_ff != '0) |=> {1'b0, rsp_tdata[SAMPLE_W-1:0]} < $past(bound_ff))
      else $error("response not below bound");

   // The remainder unit is never restarted while it is working.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !div_cmd.start)
      else $error("remainder unit restarted while busy");

endmodule
